>>> design/trps_pkg.sv
package trps_pkg;

    localparam int MAX_RUN = 32;
    localparam int PIX_W   = 24;
    localparam int CNT_W   = $clog2(MAX_RUN + 1);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Control broadcast to every cell of the run chain
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctl_t;

endpackage

>>> design/trps_cell.sv
module trps_cell
    import trps_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  pix_t      pix,
    input  logic      occupied,
    input  pix_t      left_val,
    input  logic      left_gt,
    input  pix_t      right_val,
    output pix_t      val,
    output logic      gt
);

    pix_t val_reg;
    pix_t val_next;

    // An empty cell counts as greater, so the new pixel lands at the end of the run
    assign gt  = !occupied || (val_reg > pix);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.insert && gt)
        begin
            // shift up behind the insertion point, take the pixel at it
            val_next = left_gt ? left_val : pix;
        end
        else if (ctl.shift)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

>>> design/threshold_run_pixel_sorter_core.sv
// Channel  | Handshake            | Beat payload
// ---------+----------------------+-----------------------------------
// input    | in_valid / in_ready  | pixel_in, line_end
// output   | out_valid / out_ready| pixel_out, run_last, line_last
// config   | cfg_we (no wait)     | cfg_data -> threshold
//
// Every accepted bright pixel inserts into the sorted cell chain.
// A run of n pixels drains from the head of the chain one beat per cycle, plus one more
// beat for a dark boundary pixel; input is held off for the whole drain.
// Output stalls hold the drain; the output register frees as soon as its beat is taken.
// Reset clears the run count, the control state and the threshold.
module threshold_run_pixel_sorter_core
    import trps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PIX_W-1:0]     pixel_in,
    input  logic                 line_end,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 run_last,
    output logic                 line_last,
    input  logic                 cfg_we,
    input  logic [PIX_W-1:0]     cfg_data
);

    typedef enum logic {ST_IDLE, ST_FLUSH} state_t;

    state_t    state_reg, state_next;
    pix_t      threshold_reg, threshold_next;
    cnt_t      count_reg, count_next;
    logic      bnd_pend_reg, bnd_pend_next;
    pix_t      bnd_pix_reg, bnd_pix_next;
    logic      le_reg, le_next;
    logic      out_valid_reg, out_valid_next;
    pix_t      pixel_out_reg, pixel_out_next;
    logic      run_last_reg, run_last_next;
    logic      line_last_reg, line_last_next;

    cell_ctl_t ctl;
    pix_t      cell_val [MAX_RUN];
    logic      cell_gt  [MAX_RUN];
    logic      load_ok;
    logic      accept;
    logic      bright;
    cnt_t      count_inc;

    assign load_ok  = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && load_ok;
    assign accept   = in_valid && in_ready;
    assign bright   = pixel_in > threshold_reg;
    assign count_inc = count_reg + cnt_t'(1);

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign run_last  = run_last_reg;
    assign line_last = line_last_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RUN; gi++)
        begin : g_cell
            pix_t left_val;
            logic left_gt;
            pix_t right_val;

            if (gi == 0)
            begin : g_head
                assign left_val = pixel_in;
                assign left_gt  = 1'b0;
            end
            else
            begin : g_body
                assign left_val = cell_val[gi-1];
                assign left_gt  = cell_gt[gi-1];
            end

            if (gi == MAX_RUN - 1)
            begin : g_tail
                assign right_val = cell_val[gi];
            end
            else
            begin : g_inner
                assign right_val = cell_val[gi+1];
            end

            trps_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .pix       (pixel_in),
                .occupied  (cnt_t'(gi) < count_reg),
                .left_val  (left_val),
                .left_gt   (left_gt),
                .right_val (right_val),
                .val       (cell_val[gi]),
                .gt        (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        threshold_next = cfg_we ? cfg_data : threshold_reg;
        count_next     = count_reg;
        bnd_pend_next  = bnd_pend_reg;
        bnd_pix_next   = bnd_pix_reg;
        le_next        = le_reg;
        out_valid_next = out_valid_reg && !out_ready;
        pixel_out_next = pixel_out_reg;
        run_last_next  = run_last_reg;
        line_last_next = line_last_reg;
        ctl.insert     = 1'b0;
        ctl.shift      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    le_next = line_end;
                    if (bright)
                    begin
                        ctl.insert    = 1'b1;
                        count_next    = count_inc;
                        bnd_pend_next = 1'b0;
                        if (count_inc == cnt_t'(MAX_RUN) || line_end)
                            state_next = ST_FLUSH;
                    end
                    else if (count_reg == '0)
                    begin
                        // dark pixel, no run pending: pass it straight out
                        out_valid_next = 1'b1;
                        pixel_out_next = pixel_in;
                        run_last_next  = 1'b1;
                        line_last_next = line_end;
                    end
                    else
                    begin
                        // hold the boundary pixel until the run has drained
                        bnd_pend_next = 1'b1;
                        bnd_pix_next  = pixel_in;
                        state_next    = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg != '0)
                    begin
                        ctl.shift      = 1'b1;
                        count_next     = count_reg - cnt_t'(1);
                        pixel_out_next = cell_val[0];
                        run_last_next  = (count_reg == cnt_t'(1)) && !bnd_pend_reg;
                        line_last_next = (count_reg == cnt_t'(1)) && !bnd_pend_reg && le_reg;
                        if (count_reg == cnt_t'(1) && !bnd_pend_reg)
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        pixel_out_next = bnd_pix_reg;
                        run_last_next  = 1'b1;
                        line_last_next = le_reg;
                        bnd_pend_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            threshold_reg <= '0;
            count_reg     <= '0;
            bnd_pend_reg  <= 1'b0;
            bnd_pix_reg   <= '0;
            le_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            pixel_out_reg <= '0;
            run_last_reg  <= 1'b0;
            line_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            threshold_reg <= threshold_next;
            count_reg     <= count_next;
            bnd_pend_reg  <= bnd_pend_next;
            bnd_pix_reg   <= bnd_pix_next;
            le_reg        <= le_next;
            out_valid_reg <= out_valid_next;
            pixel_out_reg <= pixel_out_next;
            run_last_reg  <= run_last_next;
            line_last_reg <= line_last_next;
        end
    end

endmodule
